>>> rtl/core/ite_pkg.sv
package ite_pkg;

   // Fixed-point format of every intermediate value: signed, VALUE_WIDTH bits,
   // FRACTION_BITS of them below the binary point.
   localparam int VALUE_WIDTH   = 32;
   localparam int FRACTION_BITS = 16;

   // Widths fixed by the token and result fields.
   localparam int NUM_W = 31;
   localparam int RES_W = 32;

   // Magnitude of a non-negative term, and the shared adder, one bit wider
   // than a signed value so that a sum of two values never wraps.
   localparam int MAG_W = VALUE_WIDTH - 1;
   localparam int SU_W  = VALUE_WIDTH + 1;
   localparam int CNT_W = $clog2(MAG_W + 1);

   localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_SYNTAX   = 2'd1,
      ERR_DIV_ZERO = 2'd2,
      ERR_OVERFLOW = 2'd3
   } err_type;

   typedef struct packed {
      logic [SU_W-1:0] a;
      logic [SU_W-1:0] b;
      logic            subtract;
   } su_req_type;

endpackage

>>> rtl/core/infix_token_evaluator.sv
// A plain token is taken in S_IDLE. A number that follows * or / then runs 31
// shift-add or quotient steps of the shared adder and a finish (a divide by zero or
// an overflowing quotient skips the steps). A final token then passes the end check and
// the output load before rsp_valid. Tokens are taken one per cycle while idle; req_stall
// holds the next token while the shared adder works one bit per step for * and /.
// Reset is synchronous and clears the evaluator state and the output valid.
module infix_token_evaluator (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_type,
   input  logic [ite_pkg::NUM_W-1:0]        req_number_value,
   input  logic [1:0]                       req_operator_code,
   input  logic                             req_end_of_expression,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [ite_pkg::RES_W-1:0] rsp_result_value,
   output logic [1:0]                       rsp_error_code
);

   localparam int MW = ite_pkg::MAG_W;
   localparam int VW = ite_pkg::VALUE_WIDTH;
   localparam int SW = ite_pkg::SU_W;
   localparam int NW = ite_pkg::NUM_W + ite_pkg::MAG_W;
   localparam int DX_W = ite_pkg::MAG_W + ite_pkg::FRACTION_BITS + 1;
   localparam int PW = 2 * ite_pkg::MAG_W;

   localparam logic signed [VW-1:0] VAL_MAX = {1'b0, ite_pkg::MAG_MAX};
   localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {MW{1'b0}}};

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_DIV,
      S_END,
      S_OUT
   } state_type;

   function automatic ite_pkg::err_type note_error(ite_pkg::err_type seen,
                                                   ite_pkg::err_type code);
      return (seen == ite_pkg::ERR_NONE) ? code : seen;
   endfunction

   state_type                  state_ff, state_in;
   logic signed [VW-1:0]       sum_ff, sum_in;
   logic                       minus_ff, minus_in;
   logic [MW-1:0]              prod_ff, prod_in;
   ite_pkg::op_type            mop_ff, mop_in;
   logic                       expect_ff, expect_in;
   ite_pkg::err_type           err_ff, err_in;
   logic                       last_ff, last_in;
   logic [ite_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [MW-1:0]              opnd_ff, opnd_in;
   logic [MW-1:0]              hi_ff, hi_in;
   logic [MW-1:0]              lo_ff, lo_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [ite_pkg::RES_W-1:0]  rsp_value_ff, rsp_value_in;
   ite_pkg::err_type           rsp_err_ff, rsp_err_in;

   ite_pkg::su_req_type        su_req;
   logic [SW-1:0]              su_sum;

   logic [NW-1:0]              num_wide;
   logic                       num_over;
   logic [MW-1:0]              x_mag;
   logic [DX_W-1:0]            dvd_ext;
   logic [DX_W-1:0]            div_top;
   logic                       div_over;
   logic [PW-1:0]              prod_full;
   logic [PW-1:0]              prod_shift;
   logic                       mul_over;
   logic                       add_over;
   logic signed [VW-1:0]       add_val;
   logic [MW:0]                rem_shift;
   logic                       borrow;
   logic [ite_pkg::RES_W-1:0]  sum_sx;
   ite_pkg::op_type            tok_op;

   ite_addsub u_addsub (
      .su_req (su_req),
      .su_sum (su_sum)
   );

   always_comb begin
      num_wide = NW'(req_number_value);
      num_over = num_wide > NW'(ite_pkg::MAG_MAX);
      x_mag    = num_over ? ite_pkg::MAG_MAX : num_wide[MW-1:0];

      // The quotient overflows exactly when the part of the dividend above the
      // quotient width is already no smaller than the divisor.
      dvd_ext  = DX_W'(prod_ff) << ite_pkg::FRACTION_BITS;
      div_top  = dvd_ext >> MW;
      div_over = div_top >= DX_W'(x_mag);

      prod_full  = {hi_ff, lo_ff};
      prod_shift = prod_full >> ite_pkg::FRACTION_BITS;
      mul_over   = |prod_shift[PW-1:MW];

      rem_shift = {hi_ff, lo_ff[MW-1]};
      tok_op    = ite_pkg::op_type'(req_operator_code);
      sum_sx    = ite_pkg::RES_W'(sum_ff);

      case (state_ff)
         S_MUL: begin
            su_req.a        = SW'(hi_ff);
            su_req.b        = lo_ff[0] ? SW'(opnd_ff) : '0;
            su_req.subtract = 1'b0;
         end
         S_DIV: begin
            su_req.a        = SW'(rem_shift);
            su_req.b        = SW'(opnd_ff);
            su_req.subtract = 1'b1;
         end
         default: begin
            su_req.a        = {sum_ff[VW-1], sum_ff};
            su_req.b        = SW'(prod_ff);
            su_req.subtract = minus_ff;
         end
      endcase

      borrow   = su_sum[SW-1];
      add_over = su_sum[SW-1] ^ su_sum[SW-2];
      add_val  = add_over ? (su_sum[SW-1] ? VAL_MIN : VAL_MAX) : su_sum[VW-1:0];
   end

   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      minus_in     = minus_ff;
      prod_in      = prod_ff;
      mop_in       = mop_ff;
      expect_in    = expect_ff;
      err_in       = err_ff;
      last_in      = last_ff;
      cnt_in       = cnt_ff;
      opnd_in      = opnd_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_err_in   = rsp_err_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               last_in  = req_end_of_expression;
               state_in = req_end_of_expression ? S_END : S_IDLE;
               if (!req_type) begin
                  if (!expect_ff) begin
                     err_in = note_error(err_in, ite_pkg::ERR_SYNTAX);
                  end else begin
                     if (num_over) begin
                        err_in = note_error(err_in, ite_pkg::ERR_OVERFLOW);
                     end
                     if (mop_ff == ite_pkg::OP_MUL) begin
                        opnd_in  = prod_ff;
                        hi_in    = '0;
                        lo_in    = x_mag;
                        cnt_in   = ite_pkg::CNT_W'(MW);
                        state_in = S_MUL;
                     end else if (mop_ff == ite_pkg::OP_DIV) begin
                        if (x_mag == '0) begin
                           err_in  = note_error(err_in, ite_pkg::ERR_DIV_ZERO);
                           prod_in = '0;
                        end else if (div_over) begin
                           err_in  = note_error(err_in, ite_pkg::ERR_OVERFLOW);
                           prod_in = ite_pkg::MAG_MAX;
                        end else begin
                           opnd_in  = x_mag;
                           hi_in    = div_top[MW-1:0];
                           lo_in    = dvd_ext[MW-1:0];
                           cnt_in   = ite_pkg::CNT_W'(MW);
                           state_in = S_DIV;
                        end
                     end else begin
                        prod_in = x_mag;
                     end
                     // Plus doubles as "no multiplicative operator pending".
                     mop_in    = ite_pkg::OP_ADD;
                     expect_in = 1'b0;
                  end
               end else begin
                  if (expect_ff) begin
                     err_in = note_error(err_in, ite_pkg::ERR_SYNTAX);
                  end else if (tok_op == ite_pkg::OP_MUL || tok_op == ite_pkg::OP_DIV) begin
                     mop_in    = tok_op;
                     expect_in = 1'b1;
                  end else begin
                     // Close the current term into the running sum.
                     sum_in = add_val;
                     if (add_over) begin
                        err_in = note_error(err_in, ite_pkg::ERR_OVERFLOW);
                     end
                     minus_in  = (tok_op == ite_pkg::OP_SUB);
                     prod_in   = '0;
                     mop_in    = ite_pkg::OP_ADD;
                     expect_in = 1'b1;
                  end
               end
            end
         end
         S_MUL: begin
            if (cnt_ff == '0) begin
               prod_in = mul_over ? ite_pkg::MAG_MAX : prod_shift[MW-1:0];
               if (mul_over) begin
                  err_in = note_error(err_in, ite_pkg::ERR_OVERFLOW);
               end
               state_in = last_ff ? S_END : S_IDLE;
            end else begin
               hi_in  = su_sum[MW:1];
               lo_in  = {su_sum[0], lo_ff[MW-1:1]};
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_DIV: begin
            if (cnt_ff == '0) begin
               prod_in  = lo_ff;
               state_in = last_ff ? S_END : S_IDLE;
            end else begin
               hi_in  = borrow ? rem_shift[MW-1:0] : su_sum[MW-1:0];
               lo_in  = {lo_ff[MW-2:0], ~borrow};
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_END: begin
            if (expect_ff) begin
               // An expression that ends while a number is still due has value zero.
               err_in = note_error(err_in, ite_pkg::ERR_SYNTAX);
               sum_in = '0;
            end else begin
               sum_in = add_val;
               if (add_over) begin
                  err_in = note_error(err_in, ite_pkg::ERR_OVERFLOW);
               end
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               rsp_valid_in = 1'b1;
               rsp_err_in   = err_ff;
               if (err_ff == ite_pkg::ERR_SYNTAX || err_ff == ite_pkg::ERR_DIV_ZERO) begin
                  rsp_value_in = '0;
               end else begin
                  rsp_value_in = sum_sx;
               end
               sum_in    = '0;
               minus_in  = 1'b0;
               prod_in   = '0;
               mop_in    = ite_pkg::OP_ADD;
               expect_in = 1'b1;
               err_in    = ite_pkg::ERR_NONE;
               last_in   = 1'b0;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sum_ff       <= '0;
         minus_ff     <= 1'b0;
         prod_ff      <= '0;
         mop_ff       <= ite_pkg::OP_ADD;
         expect_ff    <= 1'b1;
         err_ff       <= ite_pkg::ERR_NONE;
         last_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         minus_ff     <= minus_in;
         prod_ff      <= prod_in;
         mop_ff       <= mop_in;
         expect_ff    <= expect_in;
         err_ff       <= err_in;
         last_ff      <= last_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      opnd_ff      <= opnd_in;
      hi_ff        <= hi_in;
      lo_ff        <= lo_in;
      rsp_value_ff <= rsp_value_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_error_code   = rsp_err_ff;

   // A new beat appears on the result side only out of the output-load state.
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("result beat raised outside the output-load state");

   // Each multiply or divide step counts down by one and stays in its state.
   a_step_count: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_MUL || state_ff == S_DIV) && cnt_ff != '0) |=>
      (state_ff == $past(state_ff) && cnt_ff == $past(cnt_ff) - 1'b1))
      else $error("iteration counter skipped a step");

   // Loading a result returns the evaluator to the start of an expression.
   a_out_restarts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && !(rsp_valid_ff && rsp_stall)) |=>
      (state_ff == S_IDLE && expect_ff && rsp_valid_ff && err_ff == ite_pkg::ERR_NONE))
      else $error("evaluator state not restarted after a result");

   // Syntax and divide-by-zero results carry a zero value.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_error_code == ite_pkg::ERR_SYNTAX ||
                     rsp_error_code == ite_pkg::ERR_DIV_ZERO)) |->
      (rsp_result_value == '0))
      else $error("error result carries a nonzero value");

endmodule

>>> rtl/core/ite_addsub.sv
// Shared add/subtract unit. Serves the shift-add multiply, the restoring
// divide and the saturating sum of terms.
module ite_addsub (
   input  ite_pkg::su_req_type          su_req,
   output logic [ite_pkg::SU_W-1:0]     su_sum
);

   logic [ite_pkg::SU_W-1:0] b_sel;

   always_comb begin
      b_sel  = su_req.subtract ? ~su_req.b : su_req.b;
      su_sum = su_req.a + b_sel + ite_pkg::SU_W'(su_req.subtract);
   end

endmodule
